@@ src/tcpr_pkg.sv @@
// Shared types, constants and font table for the text character pixel renderer.
package tcpr_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 200;
	localparam int TEXT_COLUMNS  = 40;

	localparam int COORD_W  = 11;  // holds 255*8+7 and screen sizes up to 1024
	localparam int ADDR_W   = 16;
	localparam int COLOR_W  = 8;
	localparam int GLYPH_W  = 7;   // 96 glyphs
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_FIRST   = 8'd32;
	localparam logic [7:0] CODE_LAST    = 8'd127;

	localparam logic MODE_PUT    = 1'b0;
	localparam logic MODE_CURSOR = 1'b1;

	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	localparam logic [COLOR_W-1:0] FG_RESET = 8'd100;
	localparam logic [COLOR_W-1:0] BG_RESET = 8'd0;

	typedef struct packed {
		logic       mode;
		logic [7:0] char_code;
		logic [7:0] new_line;
		logic [7:0] new_col;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pixel_address;
		logic [7:0]  pixel_color;
		logic        last;
	} out_item_t;

	// One glyph to draw, already clipped to the visible rectangle.
	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic [2:0]         row_max;
		logic [2:0]         col_max;
		logic [ADDR_W-1:0]  start_addr;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} fifo_head_t;

	localparam logic [7:0] GLYPH_ROM [0:767] = '{
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h30,8'h78,8'h78,8'h30,8'h30,8'h00,8'h30,8'h00,
		8'h6C,8'h6C,8'h6C,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h6C,8'h6C,8'hFE,8'h6C,8'hFE,8'h6C,8'h6C,8'h00,
		8'h30,8'h7C,8'hC0,8'h78,8'h0C,8'hF8,8'h30,8'h00,
		8'h00,8'hC6,8'hCC,8'h18,8'h30,8'h66,8'hC6,8'h00,
		8'h38,8'h6C,8'h38,8'h76,8'hDC,8'hCC,8'h76,8'h00,
		8'h60,8'h60,8'hC0,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h18,8'h30,8'h60,8'h60,8'h60,8'h30,8'h18,8'h00,
		8'h60,8'h30,8'h18,8'h18,8'h18,8'h30,8'h60,8'h00,
		8'h00,8'h66,8'h3C,8'hFF,8'h3C,8'h66,8'h00,8'h00,
		8'h00,8'h30,8'h30,8'hFC,8'h30,8'h30,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h30,8'h30,8'h60,
		8'h00,8'h00,8'h00,8'hFC,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h30,8'h30,8'h00,
		8'h06,8'h0C,8'h18,8'h30,8'h60,8'hC0,8'h80,8'h00,
		8'h7C,8'hC6,8'hCE,8'hDE,8'hF6,8'hE6,8'h7C,8'h00,
		8'h30,8'h70,8'h30,8'h30,8'h30,8'h30,8'hFC,8'h00,
		8'h78,8'hCC,8'h0C,8'h38,8'h60,8'hCC,8'hFC,8'h00,
		8'h78,8'hCC,8'h0C,8'h38,8'h0C,8'hCC,8'h78,8'h00,
		8'h1C,8'h3C,8'h6C,8'hCC,8'hFE,8'h0C,8'h1E,8'h00,
		8'hFC,8'hC0,8'hF8,8'h0C,8'h0C,8'hCC,8'h78,8'h00,
		8'h38,8'h60,8'hC0,8'hF8,8'hCC,8'hCC,8'h78,8'h00,
		8'hFC,8'hCC,8'h0C,8'h18,8'h30,8'h30,8'h30,8'h00,
		8'h78,8'hCC,8'hCC,8'h78,8'hCC,8'hCC,8'h78,8'h00,
		8'h78,8'hCC,8'hCC,8'h7C,8'h0C,8'h18,8'h70,8'h00,
		8'h00,8'h30,8'h30,8'h00,8'h00,8'h30,8'h30,8'h00,
		8'h00,8'h30,8'h30,8'h00,8'h00,8'h30,8'h30,8'h60,
		8'h18,8'h30,8'h60,8'hC0,8'h60,8'h30,8'h18,8'h00,
		8'h00,8'h00,8'hFC,8'h00,8'h00,8'hFC,8'h00,8'h00,
		8'h60,8'h30,8'h18,8'h0C,8'h18,8'h30,8'h60,8'h00,
		8'h78,8'hCC,8'h0C,8'h18,8'h30,8'h00,8'h30,8'h00,
		8'h7C,8'hC6,8'hDE,8'hDE,8'hDE,8'hC0,8'h78,8'h00,
		8'h30,8'h78,8'hCC,8'hCC,8'hFC,8'hCC,8'hCC,8'h00,
		8'hFC,8'h66,8'h66,8'h7C,8'h66,8'h66,8'hFC,8'h00,
		8'h3C,8'h66,8'hC0,8'hC0,8'hC0,8'h66,8'h3C,8'h00,
		8'hF8,8'h6C,8'h66,8'h66,8'h66,8'h6C,8'hF8,8'h00,
		8'hFE,8'h62,8'h68,8'h78,8'h68,8'h62,8'hFE,8'h00,
		8'hFE,8'h62,8'h68,8'h78,8'h68,8'h60,8'hF0,8'h00,
		8'h3C,8'h66,8'hC0,8'hC0,8'hCE,8'h66,8'h3E,8'h00,
		8'hCC,8'hCC,8'hCC,8'hFC,8'hCC,8'hCC,8'hCC,8'h00,
		8'h78,8'h30,8'h30,8'h30,8'h30,8'h30,8'h78,8'h00,
		8'h1E,8'h0C,8'h0C,8'h0C,8'hCC,8'hCC,8'h78,8'h00,
		8'hE6,8'h66,8'h6C,8'h78,8'h6C,8'h66,8'hE6,8'h00,
		8'hF0,8'h60,8'h60,8'h60,8'h62,8'h66,8'hFE,8'h00,
		8'hC6,8'hEE,8'hFE,8'hFE,8'hD6,8'hC6,8'hC6,8'h00,
		8'hC6,8'hE6,8'hF6,8'hDE,8'hCE,8'hC6,8'hC6,8'h00,
		8'h38,8'h6C,8'hC6,8'hC6,8'hC6,8'h6C,8'h38,8'h00,
		8'hFC,8'h66,8'h66,8'h7C,8'h60,8'h60,8'hF0,8'h00,
		8'h78,8'hCC,8'hCC,8'hCC,8'hDC,8'h78,8'h1C,8'h00,
		8'hFC,8'h66,8'h66,8'h7C,8'h6C,8'h66,8'hE6,8'h00,
		8'h78,8'hCC,8'hE0,8'h70,8'h1C,8'hCC,8'h78,8'h00,
		8'hFC,8'hB4,8'h30,8'h30,8'h30,8'h30,8'h78,8'h00,
		8'hCC,8'hCC,8'hCC,8'hCC,8'hCC,8'hCC,8'hFC,8'h00,
		8'hCC,8'hCC,8'hCC,8'hCC,8'hCC,8'h78,8'h30,8'h00,
		8'hC6,8'hC6,8'hC6,8'hD6,8'hFE,8'hEE,8'hC6,8'h00,
		8'hC6,8'hC6,8'h6C,8'h38,8'h38,8'h6C,8'hC6,8'h00,
		8'hCC,8'hCC,8'hCC,8'h78,8'h30,8'h30,8'h78,8'h00,
		8'hFE,8'hC6,8'h8C,8'h18,8'h32,8'h66,8'hFE,8'h00,
		8'h78,8'h60,8'h60,8'h60,8'h60,8'h60,8'h78,8'h00,
		8'hC0,8'h60,8'h30,8'h18,8'h0C,8'h06,8'h02,8'h00,
		8'h78,8'h18,8'h18,8'h18,8'h18,8'h18,8'h78,8'h00,
		8'h10,8'h38,8'h6C,8'hC6,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hFF,
		8'h30,8'h30,8'h18,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h78,8'h0C,8'h7C,8'hCC,8'h76,8'h00,
		8'hE0,8'h60,8'h60,8'h7C,8'h66,8'h66,8'hDC,8'h00,
		8'h00,8'h00,8'h78,8'hCC,8'hC0,8'hCC,8'h78,8'h00,
		8'h1C,8'h0C,8'h0C,8'h7C,8'hCC,8'hCC,8'h76,8'h00,
		8'h00,8'h00,8'h78,8'hCC,8'hFC,8'hC0,8'h78,8'h00,
		8'h38,8'h6C,8'h60,8'hF0,8'h60,8'h60,8'hF0,8'h00,
		8'h00,8'h00,8'h76,8'hCC,8'hCC,8'h7C,8'h0C,8'hF8,
		8'hE0,8'h60,8'h6C,8'h76,8'h66,8'h66,8'hE6,8'h00,
		8'h30,8'h00,8'h70,8'h30,8'h30,8'h30,8'h78,8'h00,
		8'h0C,8'h00,8'h0C,8'h0C,8'h0C,8'hCC,8'hCC,8'h78,
		8'hE0,8'h60,8'h66,8'h6C,8'h78,8'h6C,8'hE6,8'h00,
		8'h70,8'h30,8'h30,8'h30,8'h30,8'h30,8'h78,8'h00,
		8'h00,8'h00,8'hCC,8'hFE,8'hFE,8'hD6,8'hC6,8'h00,
		8'h00,8'h00,8'hF8,8'hCC,8'hCC,8'hCC,8'hCC,8'h00,
		8'h00,8'h00,8'h78,8'hCC,8'hCC,8'hCC,8'h78,8'h00,
		8'h00,8'h00,8'hDC,8'h66,8'h66,8'h7C,8'h60,8'hF0,
		8'h00,8'h00,8'h76,8'hCC,8'hCC,8'h7C,8'h0C,8'h1E,
		8'h00,8'h00,8'hDC,8'h76,8'h66,8'h60,8'hF0,8'h00,
		8'h00,8'h00,8'h7C,8'hC0,8'h78,8'h0C,8'hF8,8'h00,
		8'h10,8'h30,8'h7C,8'h30,8'h30,8'h34,8'h18,8'h00,
		8'h00,8'h00,8'hCC,8'hCC,8'hCC,8'hCC,8'h76,8'h00,
		8'h00,8'h00,8'hCC,8'hCC,8'hCC,8'h78,8'h30,8'h00,
		8'h00,8'h00,8'hC6,8'hD6,8'hFE,8'hFE,8'h6C,8'h00,
		8'h00,8'h00,8'hC6,8'h6C,8'h38,8'h6C,8'hC6,8'h00,
		8'h00,8'h00,8'hCC,8'hCC,8'hCC,8'h7C,8'h0C,8'hF8,
		8'h00,8'h00,8'hFC,8'h98,8'h30,8'h64,8'hFC,8'h00,
		8'h1C,8'h30,8'h30,8'hE0,8'h30,8'h30,8'h1C,8'h00,
		8'h18,8'h18,8'h18,8'h00,8'h18,8'h18,8'h18,8'h00,
		8'hE0,8'h30,8'h30,8'h1C,8'h30,8'h30,8'hE0,8'h00,
		8'h76,8'hDC,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h10,8'h38,8'h6C,8'hC6,8'hC6,8'hFE,8'h00
	};

endpackage

@@ src/tcpr_front.sv @@
// Front end: takes items, keeps the text cursor, turns drawable characters into clipped jobs.
module tcpr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  tcpr_pkg::in_item_t  item,
	output logic                push,
	output tcpr_pkg::job_t      job
);
	import tcpr_pkg::*;

	logic [7:0]           row_q;
	logic [7:0]           col_q;
	logic [7:0]           clamp_code;
	logic [8:0]           next_col;
	logic [7:0]           row_inc;
	logic [COORD_W-1:0]   base_x;
	logic [COORD_W-1:0]   base_y;
	logic [COORD_W-1:0]   room_x;
	logic [COORD_W-1:0]   room_y;
	logic [2*COORD_W-1:0] row_prod;
	logic                 vis_x;
	logic                 vis_y;
	logic                 is_draw;

	assign row_inc = (row_q != 8'hFF) ? row_q + 8'd1 : row_q;
	assign next_col = {1'b0, col_q} + 9'd1;

	always_comb begin
		priority if (item.char_code < CODE_FIRST) begin
			clamp_code = CODE_FIRST;
		end else if (item.char_code > CODE_LAST) begin
			clamp_code = CODE_LAST;
		end else begin
			clamp_code = item.char_code;
		end
	end

	assign base_x = {col_q, 3'b000};
	assign base_y = {row_q, 3'b000};
	assign vis_x = base_x < COORD_W'(SCREEN_WIDTH);
	assign vis_y = base_y < COORD_W'(SCREEN_HEIGHT);
	assign room_x = COORD_W'(SCREEN_WIDTH) - base_x;
	assign room_y = COORD_W'(SCREEN_HEIGHT) - base_y;
	assign row_prod = (2*COORD_W)'(base_y) * (2*COORD_W)'(SCREEN_WIDTH);

	assign is_draw = (item.mode == MODE_PUT) && (item.char_code != CODE_NEWLINE);

	always_comb begin
		job.glyph      = GLYPH_W'(clamp_code - CODE_FIRST);
		job.col_max    = (room_x >= COORD_W'(8)) ? 3'd7 : 3'(room_x - COORD_W'(1));
		job.row_max    = (room_y >= COORD_W'(8)) ? 3'd7 : 3'(room_y - COORD_W'(1));
		job.start_addr = ADDR_W'(row_prod) + ADDR_W'(base_x);
	end

	// fully clipped characters still move the cursor but make no job
	assign push = accept && is_draw && vis_x && vis_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			priority if (item.mode == MODE_CURSOR) begin
				row_q <= item.new_line;
				col_q <= item.new_col;
			end else if (item.char_code == CODE_NEWLINE) begin
				row_q <= row_inc;
				col_q <= '0;
			end else if (next_col >= 9'(TEXT_COLUMNS)) begin
				row_q <= row_inc;
				col_q <= '0;
			end else begin
				col_q <= next_col[7:0];
			end
		end
	end

endmodule

@@ src/tcpr_fifo.sv @@
// Short job queue between front and back ends.
module tcpr_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tcpr_pkg::job_t        push_job,
	input  logic                  pop,
	output tcpr_pkg::fifo_head_t  head,
	output logic                  full
);
	import tcpr_pkg::*;

	job_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_pop;

	assign full = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.job = mem_q[rd_q];
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + FIFO_PTR_W'(1);
			end
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ src/tcpr_back.sv @@
// Back end: walks visible job pixels, one per cycle unless stalled, into the output register.
module tcpr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcpr_pkg::fifo_head_t        head,
	output logic                        pop,
	input  logic [tcpr_pkg::COLOR_W-1:0] fg_color,
	input  logic [tcpr_pkg::COLOR_W-1:0] bg_color,
	output logic                        busy,
	output logic                        pix_valid,
	input  logic                        pix_stall,
	output tcpr_pkg::out_item_t         pix
);
	import tcpr_pkg::*;

	logic               active_q, active_n;
	logic [GLYPH_W-1:0] glyph_q, glyph_n;
	logic [2:0]         row_q, row_n;
	logic [2:0]         bit_q, bit_n;
	logic [2:0]         row_max_q, row_max_n;
	logic [2:0]         col_max_q, col_max_n;
	logic [ADDR_W-1:0]  row_addr_q, row_addr_n;
	logic [7:0]         rom_q;
	logic               out_valid_q;
	out_item_t          out_q;
	logic               adv;
	logic               is_last;
	logic               take;

	assign adv = active_q && (!out_valid_q || !pix_stall);
	assign is_last = (row_q == row_max_q) && (bit_q == col_max_q);
	assign take = !active_q || (adv && is_last);
	assign pop = take && head.valid;
	assign busy = active_q;

	always_comb begin
		active_n   = active_q;
		glyph_n    = glyph_q;
		row_n      = row_q;
		bit_n      = bit_q;
		row_max_n  = row_max_q;
		col_max_n  = col_max_q;
		row_addr_n = row_addr_q;
		if (take) begin
			active_n = head.valid;
			if (head.valid) begin
				glyph_n    = head.job.glyph;
				row_n      = '0;
				bit_n      = '0;
				row_max_n  = head.job.row_max;
				col_max_n  = head.job.col_max;
				row_addr_n = head.job.start_addr;
			end
		end else if (adv) begin
			if (bit_q == col_max_q) begin
				bit_n      = '0;
				row_n      = row_q + 3'd1;
				row_addr_n = row_addr_q + ADDR_W'(SCREEN_WIDTH);
			end else begin
				bit_n = bit_q + 3'd1;
			end
		end
	end

	// font row fetched for the next cycle's glyph row, so rom_q always matches row_q
	always_ff @(posedge clk) begin
		rom_q <= GLYPH_ROM[{glyph_n, row_n}];
	end

	always_ff @(posedge clk) begin
		glyph_q    <= glyph_n;
		row_q      <= row_n;
		bit_q      <= bit_n;
		row_max_q  <= row_max_n;
		col_max_q  <= col_max_n;
		row_addr_q <= row_addr_n;
		if (adv) begin
			out_q.pixel_address <= row_addr_q + ADDR_W'(bit_q);
			out_q.pixel_color   <= rom_q[3'd7 - bit_q] ? fg_color : bg_color;
			out_q.last          <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			active_q <= active_n;
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pix_valid = out_valid_q;
	assign pix = out_q;

endmodule

@@ src/text_char_pixel_renderer.sv @@
// Top level of the 8x8 bitmap font text renderer.
//
// Draws text into a byte-per-pixel framebuffer (320x200) with a 96-glyph
// 8x8 font. An item either sets the text cursor (row, column) or puts a
// character. A newline moves to column 0 of the next row; any other code is
// clamped to 32..127 and its glyph is emitted as pixel write transactions,
// glyph rows top to bottom, each row MSB first, in fg_color for set bits and
// bg_color for clear bits. Pixels off the right or bottom edge are dropped and
// "last" marks the final pixel actually written. The column wraps after 40
// characters; the row saturates at 255.
// Timing: the front end takes one item per cycle (cursor update and clipping
// done in that cycle) while the two-entry job queue has room. The back end
// emits one pixel per cycle while the sink does not stall, and a clipped
// character yields only its visible pixels; back-to-back characters run
// with no gap between them. Set cursor, newline and fully clipped characters
// only move the cursor and produce nothing. The pixel output is held in a
// register; while the sink stalls, the back end advances only to fill that
// register when it is empty, then waits for the sink.
// Configuration: index 0 = fg_color (reset 100), index 1 = bg_color (reset 0);
// cfg_ready is always high. Write only while no character is in flight.
module text_char_pixel_renderer (
	input  logic                         clk,
	input  logic                         arst_n,
	// item channel
	input  logic                         item_valid,
	output logic                         item_stall,
	input  tcpr_pkg::in_item_t           item,
	// pixel channel
	output logic                         pix_valid,
	input  logic                         pix_stall,
	output tcpr_pkg::out_item_t          pix,
	// configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [tcpr_pkg::COLOR_W-1:0] cfg_data
);
	import tcpr_pkg::*;

	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic               accept;
	logic               push;
	logic               pop;
	logic               full;
	logic               busy;
	job_t               job;
	fifo_head_t         head;

	// ---- configuration registers ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FG: fg_q <= cfg_data;
				REG_BG: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- front: stall only while the job queue is full ----
	assign item_stall = full;
	assign accept = item_valid && !item_stall;

	tcpr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.push   (push),
		.job    (job)
	);

	tcpr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.full     (full)
	);

	// ---- back: pixel walker and output register ----
	tcpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.fg_color  (fg_q),
		.bg_color  (bg_q),
		.busy      (busy),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

`ifndef SYNTHESIS
	// a job is never written into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("job pushed into full queue");

	// with nothing queued the front must take items
	assert property (@(posedge clk) disable iff (!arst_n) !head.valid |-> !item_stall)
		else $error("front stalled with empty queue");

	// an idle walker picks up a waiting job at once
	assert property (@(posedge clk) disable iff (!arst_n) (!busy && head.valid) |=> busy)
		else $error("queued job not started");

	// every emitted pixel lies on screen
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> (pix.pixel_address < ADDR_W'(SCREEN_WIDTH * SCREEN_HEIGHT)))
		else $error("pixel address off screen");
`endif

endmodule
